// ----- rtl/tbe_pkg.sv -----
// Package: token codes, tag constants and shared types of the tagged binary object encoder.
`timescale 1ns / 1ps

package tbe_pkg;

  localparam int unsigned MAX_BYTES = 12;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned VAR_BYTES = 10;

  typedef enum logic [3:0] {
    CMD_START      = 4'd0,
    CMD_NULL       = 4'd1,
    CMD_BOOL       = 4'd2,
    CMD_TAGGED_NUM = 4'd3,
    CMD_BARE_NUM   = 4'd4,
    CMD_LEN_HDR    = 4'd5,
    CMD_VARINT     = 4'd6,
    CMD_ELEM_TAG   = 4'd7,
    CMD_RAW        = 4'd8
  } cmd_t;

  localparam logic [1:0] CLS_SIGNED   = 2'd0;
  localparam logic [1:0] CLS_UNSIGNED = 2'd1;
  localparam logic [1:0] CLS_FLOAT    = 2'd2;

  localparam logic [2:0] KIND_MAP    = 3'd0;
  localparam logic [2:0] KIND_BINARY = 3'd1;
  localparam logic [2:0] KIND_STRING = 3'd2;
  localparam logic [2:0] KIND_ARRAY  = 3'd3;
  localparam logic [2:0] KIND_TYPED  = 3'd4;

  localparam logic [2:0] ELEM_NULL   = 3'd0;
  localparam logic [2:0] ELEM_BOOL   = 3'd1;
  localparam logic [2:0] ELEM_BINARY = 3'd2;
  localparam logic [2:0] ELEM_STRING = 3'd3;
  localparam logic [2:0] ELEM_ARRAY  = 3'd4;
  localparam logic [2:0] ELEM_MAP    = 3'd5;
  localparam logic [2:0] ELEM_NUMBER = 3'd6;

  localparam logic [7:0] TAG_NULL       = 8'h01;
  localparam logic [7:0] TAG_FALSE      = 8'h02;
  localparam logic [7:0] TAG_TRUE       = 8'h03;
  localparam logic [7:0] TAG_BINARY_ANY = 8'h9F;
  localparam logic [7:0] TAG_STRING_ANY = 8'hBF;
  localparam logic [7:0] TAG_ARRAY_ANY  = 8'h5F;
  localparam logic [7:0] TAG_MAP_ANY    = 8'h3F;
  localparam logic [7:0] LEN_ESCAPE     = 8'h1F;
  localparam logic [7:0] VAR_CONT       = 8'h80;

  localparam logic [7:0] BASE_MAP    = 8'h20;
  localparam logic [7:0] BASE_BINARY = 8'h80;
  localparam logic [7:0] BASE_STRING = 8'hA0;
  localparam logic [7:0] BASE_ARRAY  = 8'h40;
  localparam logic [7:0] BASE_TYPED  = 8'h60;

  localparam logic [7:0] BASE_SIGNED   = 8'h10;
  localparam logic [7:0] BASE_UNSIGNED = 8'h18;
  localparam logic [7:0] BASE_FLOAT    = 8'h08;

  localparam logic [5:0][7:0] MAGIC = {8'h02, 8'h00, 8'h4E, 8'h4F, 8'h42, 8'h54};

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          count;
  } token_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] tag;
  } tag_t;

  function automatic tag_t number_tag(input logic [1:0] cls, input logic [1:0] size_code);
    tag_t r;
    r.ok  = 1'b1;
    r.tag = 8'h00;
    case (cls)
      CLS_SIGNED:   r.tag = BASE_SIGNED + {6'd0, size_code};
      CLS_UNSIGNED: r.tag = BASE_UNSIGNED + {6'd0, size_code};
      CLS_FLOAT:    r.tag = BASE_FLOAT + {6'd0, size_code};
      default:      r.ok  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic tag_t element_tag(input logic [2:0] elem, input logic [1:0] cls,
                                       input logic [1:0] size_code);
    tag_t r;
    r.ok  = 1'b1;
    r.tag = 8'h00;
    case (elem)
      ELEM_NULL:   r.tag = TAG_NULL;
      ELEM_BOOL:   r.tag = TAG_FALSE;
      ELEM_BINARY: r.tag = TAG_BINARY_ANY;
      ELEM_STRING: r.tag = TAG_STRING_ANY;
      ELEM_ARRAY:  r.tag = TAG_ARRAY_ANY;
      ELEM_MAP:    r.tag = TAG_MAP_ANY;
      ELEM_NUMBER: r = number_tag(cls, size_code);
      default:     r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic tag_t container_base(input logic [2:0] kind);
    tag_t r;
    r.ok  = 1'b1;
    r.tag = 8'h00;
    case (kind)
      KIND_MAP:    r.tag = BASE_MAP;
      KIND_BINARY: r.tag = BASE_BINARY;
      KIND_STRING: r.tag = BASE_STRING;
      KIND_ARRAY:  r.tag = BASE_ARRAY;
      KIND_TYPED:  r.tag = BASE_TYPED;
      default:     r.ok  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/tbe_if.sv -----
// Interfaces: token input channel and encoded byte output channel.
`timescale 1ns / 1ps

interface tbe_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic        bool_value;
  logic [1:0]  number_class;
  logic [1:0]  size_code;
  logic [63:0] number_value;
  logic [2:0]  container_kind;
  logic [63:0] length;
  logic [2:0]  element_kind;
  logic [7:0]  raw_byte;

  modport source (output valid, command, bool_value, number_class, size_code, number_value,
                  container_kind, length, element_kind, raw_byte, input ready);
  modport sink (input valid, command, bool_value, number_class, size_code, number_value,
                container_kind, length, element_kind, raw_byte, output ready);
endinterface

interface tbe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

// ----- rtl/tbe_format.sv -----
// Token formatter: turns one token into its encoded bytes and byte count.
`timescale 1ns / 1ps

module tbe_format (
  input  logic [3:0]     command,
  input  logic           bool_value,
  input  logic [1:0]     number_class,
  input  logic [1:0]     size_code,
  input  logic [63:0]    number_value,
  input  logic [2:0]     container_kind,
  input  logic [63:0]    length,
  input  logic [2:0]     element_kind,
  input  logic [7:0]     raw_byte,
  output tbe_pkg::token_t token
);

  logic [7:0][7:0]                    payload;
  logic [3:0]                         pay_n;
  logic [tbe_pkg::VAR_BYTES-1:0][7:0] var_bytes;
  logic [tbe_pkg::VAR_BYTES-1:0]      var_cont;
  logic [tbe_pkg::CNT_W-1:0]          var_n;
  tbe_pkg::tag_t                      num_tag;
  tbe_pkg::tag_t                      elem_tag;
  tbe_pkg::tag_t                      base;
  logic                               short_len;

  assign num_tag   = tbe_pkg::number_tag(number_class, size_code);
  assign elem_tag  = tbe_pkg::element_tag(element_kind, number_class, size_code);
  assign base      = tbe_pkg::container_base(container_kind);
  assign short_len = (length < 64'(tbe_pkg::LEN_ESCAPE));
  assign pay_n     = 4'd1 << size_code;

  always_comb begin
    payload = '0;
    for (int j = 0; j < 8; j++) begin
      if (j < int'(pay_n)) begin
        payload[j] = 8'(number_value >> (8 * (int'(pay_n) - 1 - j)));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < tbe_pkg::VAR_BYTES; i++) begin
      var_cont[i]  = ((length >> (7 * (i + 1))) != 64'd0);
      var_bytes[i] = (8'(length >> (7 * i)) & 8'h7F) | (var_cont[i] ? tbe_pkg::VAR_CONT : 8'h00);
    end
    var_n = tbe_pkg::CNT_W'($countones(var_cont)) + tbe_pkg::CNT_W'(1);
  end

  always_comb begin
    token = '0;
    case (tbe_pkg::cmd_t'(command))
      tbe_pkg::CMD_START: begin
        token.bytes[5:0] = tbe_pkg::MAGIC;
        token.count      = tbe_pkg::CNT_W'(6);
      end
      tbe_pkg::CMD_NULL: begin
        token.bytes[0] = tbe_pkg::TAG_NULL;
        token.count    = tbe_pkg::CNT_W'(1);
      end
      tbe_pkg::CMD_BOOL: begin
        token.bytes[0] = bool_value ? tbe_pkg::TAG_TRUE : tbe_pkg::TAG_FALSE;
        token.count    = tbe_pkg::CNT_W'(1);
      end
      tbe_pkg::CMD_TAGGED_NUM: begin
        if (num_tag.ok) begin
          token.bytes[0]   = num_tag.tag;
          token.bytes[8:1] = payload;
          token.count      = tbe_pkg::CNT_W'(pay_n) + tbe_pkg::CNT_W'(1);
        end
      end
      tbe_pkg::CMD_BARE_NUM: begin
        if (num_tag.ok) begin
          token.bytes[7:0] = payload;
          token.count      = tbe_pkg::CNT_W'(pay_n);
        end
      end
      tbe_pkg::CMD_LEN_HDR: begin
        if (base.ok) begin
          if (short_len) begin
            token.bytes[0] = base.tag + length[7:0];
            token.count    = tbe_pkg::CNT_W'(1);
          end else begin
            token.bytes[0]    = base.tag + tbe_pkg::LEN_ESCAPE;
            token.bytes[10:1] = var_bytes;
            token.count       = var_n + tbe_pkg::CNT_W'(1);
          end
          if (container_kind == tbe_pkg::KIND_TYPED && elem_tag.ok) begin
            token.bytes[token.count] = elem_tag.tag;
            token.count              = token.count + tbe_pkg::CNT_W'(1);
          end
        end
      end
      tbe_pkg::CMD_VARINT: begin
        token.bytes[9:0] = var_bytes;
        token.count      = var_n;
      end
      tbe_pkg::CMD_ELEM_TAG: begin
        if (elem_tag.ok) begin
          token.bytes[0] = elem_tag.tag;
          token.count    = tbe_pkg::CNT_W'(1);
        end
      end
      tbe_pkg::CMD_RAW: begin
        token.bytes[0] = raw_byte;
        token.count    = tbe_pkg::CNT_W'(1);
      end
      default: begin
        token = '0;
      end
    endcase
  end

endmodule

// ----- rtl/tbe_emit.sv -----
// Byte emitter: token buffer shifted out one byte a cycle, while the output is not stalled, into an output register.
`timescale 1ns / 1ps

module tbe_emit (
  input  logic              clk,
  input  logic              rst,
  input  tbe_pkg::token_t   token,
  input  logic              tok_valid,
  output logic              tok_ready,
  tbe_byte_if.source        enc
);

  logic [tbe_pkg::MAX_BYTES-1:0][7:0] bytes;
  logic [tbe_pkg::CNT_W-1:0]          rem;
  logic                               ov;
  logic [7:0]                         ob;
  logic                               ol;
  logic                               move;
  logic                               take;

  assign move      = (rem != '0) && (!ov || enc.ready);
  assign tok_ready = (rem == '0) || ((rem == tbe_pkg::CNT_W'(1)) && move);
  assign take      = tok_valid && tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
      ov  <= 1'b0;
    end else begin
      if (take) begin
        rem <= token.count;
      end else if (move) begin
        rem <= rem - tbe_pkg::CNT_W'(1);
      end
      if (move) begin
        ov <= 1'b1;
      end else if (enc.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bytes <= token.bytes;
    end else if (move) begin
      bytes <= bytes >> 8;
    end
    if (move) begin
      ob <= bytes[0];
      ol <= (rem == tbe_pkg::CNT_W'(1));
    end
  end

  assign enc.valid    = ov;
  assign enc.out_byte = ob;
  assign enc.last     = ol;

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= tbe_pkg::CNT_W'(tbe_pkg::MAX_BYTES))
    else $error("byte count above buffer depth");

  a_take_load: assert property (@(posedge clk) disable iff (rst)
    take |=> rem == $past(token.count))
    else $error("token count not loaded on accept");

  a_move_out: assert property (@(posedge clk) disable iff (rst)
    move |=> ov && ob == $past(bytes[0]) && ol == $past(rem == tbe_pkg::CNT_W'(1)))
    else $error("output register not loaded on move");

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    (rem > tbe_pkg::CNT_W'(1)) |-> !tok_ready)
    else $error("token accepted while bytes remain");

endmodule

// ----- rtl/tagged_binary_object_encoder.sv -----
// Top level: tagged binary object encoder, one token in, its encoded bytes out.
//
//   channel  dir  payload                                              last mark
//   tok      in   command, bool/number/container/length/element/raw  -
//   enc      out  out_byte                                             last
//
// A token's bytes leave the buffer one at a time through the single byte output port.
// A new token is taken in the cycle its predecessor's final byte moves out.
// Reset clears the byte count and output valid; buffer contents are not reset.
// A stalled output holds its byte; the buffer waits behind it.
`timescale 1ns / 1ps

module tagged_binary_object_encoder (
  input  logic        clk,
  input  logic        rst,
  tbe_tok_if.sink     tok,
  tbe_byte_if.source  enc
);

  tbe_pkg::token_t token;

  tbe_format u_format (
    .command        (tok.command),
    .bool_value     (tok.bool_value),
    .number_class   (tok.number_class),
    .size_code      (tok.size_code),
    .number_value   (tok.number_value),
    .container_kind (tok.container_kind),
    .length         (tok.length),
    .element_kind   (tok.element_kind),
    .raw_byte       (tok.raw_byte),
    .token          (token)
  );

  tbe_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .token     (token),
    .tok_valid (tok.valid),
    .tok_ready (tok.ready),
    .enc       (enc)
  );

endmodule

// ----- dv/testbench.sv -----
// Testbench: tagged binary object encoder, token stream in, encoded byte stream checked out.
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [3:0]  command;
    logic        bool_value;
    logic [1:0]  number_class;
    logic [1:0]  size_code;
    logic [63:0] number_value;
    logic [2:0]  container_kind;
    logic [63:0] length;
    logic [2:0]  element_kind;
    logic [7:0]  raw_byte;
  } token_item_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } enc_beat_t;

  typedef logic [7:0] byte_list_t[$];

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned TOTAL_TOKENS = 270;

  logic clk;
  logic rst;

  tbe_tok_if  tok_ch();
  tbe_byte_if enc_ch();

  tagged_binary_object_encoder u_dut (
    .clk (clk),
    .rst (rst),
    .tok (tok_ch),
    .enc (enc_ch)
  );

  token_item_t pending_tokens[$];
  enc_beat_t   expected_beats[$];
  token_item_t next_token;
  enc_beat_t   want_beat;
  byte_list_t  token_bytes_q;
  int          errors = 0;
  int          tokens_taken = 0;
  int          stall_cycles = 0;

  wire steady = (tokens_taken >= 120) && (tokens_taken < 180);

  function automatic logic [7:0] number_tag_byte(input logic [1:0] cls, input logic [1:0] sz);
    case (cls)
      tbe_pkg::CLS_SIGNED:   return tbe_pkg::BASE_SIGNED + {6'd0, sz};
      tbe_pkg::CLS_UNSIGNED: return tbe_pkg::BASE_UNSIGNED + {6'd0, sz};
      default:               return tbe_pkg::BASE_FLOAT + {6'd0, sz};
    endcase
  endfunction

  function automatic void add_varint(ref byte_list_t b, input logic [63:0] v);
    while (v >= 64'h80) begin
      b.push_back(tbe_pkg::VAR_CONT | {1'b0, v[6:0]});
      v = v >> 7;
    end
    b.push_back(v[7:0]);
  endfunction

  function automatic void add_element_tag(ref byte_list_t b, input token_item_t t);
    case (t.element_kind)
      tbe_pkg::ELEM_NULL:   b.push_back(tbe_pkg::TAG_NULL);
      tbe_pkg::ELEM_BOOL:   b.push_back(tbe_pkg::TAG_FALSE);
      tbe_pkg::ELEM_BINARY: b.push_back(tbe_pkg::TAG_BINARY_ANY);
      tbe_pkg::ELEM_STRING: b.push_back(tbe_pkg::TAG_STRING_ANY);
      tbe_pkg::ELEM_ARRAY:  b.push_back(tbe_pkg::TAG_ARRAY_ANY);
      tbe_pkg::ELEM_MAP:    b.push_back(tbe_pkg::TAG_MAP_ANY);
      tbe_pkg::ELEM_NUMBER: if (t.number_class <= tbe_pkg::CLS_FLOAT)
                              b.push_back(number_tag_byte(t.number_class, t.size_code));
      default: ;
    endcase
  endfunction

  function automatic byte_list_t encode_token(input token_item_t t);
    byte_list_t b;
    logic [7:0] base;
    int         n;
    b = {};
    case (t.command)
      tbe_pkg::CMD_START: begin
        for (int i = 0; i < 6; i++) b.push_back(tbe_pkg::MAGIC[i]);
      end
      tbe_pkg::CMD_NULL: b.push_back(tbe_pkg::TAG_NULL);
      tbe_pkg::CMD_BOOL: b.push_back(t.bool_value ? tbe_pkg::TAG_TRUE : tbe_pkg::TAG_FALSE);
      tbe_pkg::CMD_TAGGED_NUM, tbe_pkg::CMD_BARE_NUM: begin
        if (t.number_class <= tbe_pkg::CLS_FLOAT) begin
          if (t.command == tbe_pkg::CMD_TAGGED_NUM)
            b.push_back(number_tag_byte(t.number_class, t.size_code));
          n = 1 << t.size_code;
          for (int i = n - 1; i >= 0; i--) b.push_back(t.number_value[8*i +: 8]);
        end
      end
      tbe_pkg::CMD_LEN_HDR: begin
        if (t.container_kind <= tbe_pkg::KIND_TYPED) begin
          case (t.container_kind)
            tbe_pkg::KIND_MAP:    base = tbe_pkg::BASE_MAP;
            tbe_pkg::KIND_BINARY: base = tbe_pkg::BASE_BINARY;
            tbe_pkg::KIND_STRING: base = tbe_pkg::BASE_STRING;
            tbe_pkg::KIND_ARRAY:  base = tbe_pkg::BASE_ARRAY;
            default:              base = tbe_pkg::BASE_TYPED;
          endcase
          if (t.length < 64'(tbe_pkg::LEN_ESCAPE)) begin
            b.push_back(base + t.length[7:0]);
          end else begin
            b.push_back(base + tbe_pkg::LEN_ESCAPE);
            add_varint(b, t.length);
          end
          if (t.container_kind == tbe_pkg::KIND_TYPED) add_element_tag(b, t);
        end
      end
      tbe_pkg::CMD_VARINT:   add_varint(b, t.length);
      tbe_pkg::CMD_ELEM_TAG: add_element_tag(b, t);
      tbe_pkg::CMD_RAW:      b.push_back(t.raw_byte);
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [63:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_length();
    case ($urandom_range(3))
      0: return 64'($urandom_range(30));
      1: return 64'($urandom_range(33, 29));
      2: return rand_wide() >> $urandom_range(63);
      default: return (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
    endcase
  endfunction

  function automatic token_item_t rand_token();
    token_item_t t;
    int          r;
    r = $urandom_range(99);
    if (r < 5) t.command = tbe_pkg::CMD_START;
    else if (r < 10) t.command = tbe_pkg::CMD_NULL;
    else if (r < 17) t.command = tbe_pkg::CMD_BOOL;
    else if (r < 35) t.command = tbe_pkg::CMD_TAGGED_NUM;
    else if (r < 45) t.command = tbe_pkg::CMD_BARE_NUM;
    else if (r < 65) t.command = tbe_pkg::CMD_LEN_HDR;
    else if (r < 73) t.command = tbe_pkg::CMD_VARINT;
    else if (r < 81) t.command = tbe_pkg::CMD_ELEM_TAG;
    else if (r < 95) t.command = tbe_pkg::CMD_RAW;
    else t.command = 4'($urandom_range(15, 9));
    t.bool_value     = 1'($urandom_range(1));
    t.number_class   = ($urandom_range(99) < 90) ? 2'($urandom_range(2)) : 2'd3;
    t.size_code      = 2'($urandom_range(3));
    t.number_value   = rand_wide();
    t.container_kind = ($urandom_range(99) < 90) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
    t.length         = rand_length();
    t.element_kind   = 3'($urandom_range(7));
    t.raw_byte       = 8'($urandom_range(255));
    return t;
  endfunction

  function automatic token_item_t mk_token(input logic [3:0] c, input logic bv,
                                           input logic [1:0] cls, input logic [1:0] sz,
                                           input logic [63:0] v, input logic [2:0] k,
                                           input logic [63:0] len, input logic [2:0] e,
                                           input logic [7:0] rb);
    token_item_t t;
    t.command        = c;
    t.bool_value     = bv;
    t.number_class   = cls;
    t.size_code      = sz;
    t.number_value   = v;
    t.container_kind = k;
    t.length         = len;
    t.element_kind   = e;
    t.raw_byte       = rb;
    return t;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      tok_ch.valid          <= 1'b0;
      tok_ch.command        <= tbe_pkg::CMD_NULL;
      tok_ch.bool_value     <= 1'b0;
      tok_ch.number_class   <= tbe_pkg::CLS_SIGNED;
      tok_ch.size_code      <= 2'd0;
      tok_ch.number_value   <= 64'd0;
      tok_ch.container_kind <= tbe_pkg::KIND_MAP;
      tok_ch.length         <= 64'd0;
      tok_ch.element_kind   <= tbe_pkg::ELEM_NULL;
      tok_ch.raw_byte       <= 8'd0;
    end else if (!tok_ch.valid || tok_ch.ready) begin
      if (pending_tokens.size() > 0 && (steady || $urandom_range(99) >= 20)) begin
        next_token = pending_tokens.pop_front();
        tok_ch.valid          <= 1'b1;
        tok_ch.command        <= next_token.command;
        tok_ch.bool_value     <= next_token.bool_value;
        tok_ch.number_class   <= next_token.number_class;
        tok_ch.size_code      <= next_token.size_code;
        tok_ch.number_value   <= next_token.number_value;
        tok_ch.container_kind <= next_token.container_kind;
        tok_ch.length         <= next_token.length;
        tok_ch.element_kind   <= next_token.element_kind;
        tok_ch.raw_byte       <= next_token.raw_byte;
      end else begin
        tok_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) enc_ch.ready <= 1'b0;
    else enc_ch.ready <= steady || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && tok_ch.valid && tok_ch.ready) begin
      token_bytes_q = encode_token(mk_token(tok_ch.command, tok_ch.bool_value,
                                            tok_ch.number_class, tok_ch.size_code,
                                            tok_ch.number_value, tok_ch.container_kind,
                                            tok_ch.length, tok_ch.element_kind,
                                            tok_ch.raw_byte));
      foreach (token_bytes_q[i])
        expected_beats.push_back('{token_bytes_q[i], i == token_bytes_q.size() - 1});
      tokens_taken <= tokens_taken + 1;
    end
    if (!rst && enc_ch.valid && enc_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual byte %02h last %0b",
                 $time, enc_ch.out_byte, enc_ch.last);
        errors++;
      end else begin
        want_beat = expected_beats.pop_front();
        if (enc_ch.out_byte !== want_beat.data || enc_ch.last !== want_beat.last) begin
          $display("%0t: beat mismatch: expected byte %02h last %0b, actual byte %02h last %0b",
                   $time, want_beat.data, want_beat.last, enc_ch.out_byte, enc_ch.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (tok_ch.valid && tok_ch.ready) || (enc_ch.valid && enc_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tagged_binary_object_encoder regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    token_item_t t;
    rst = 1'b1;

    pending_tokens.push_back(mk_token(tbe_pkg::CMD_START, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_NULL, 1, tbe_pkg::CLS_FLOAT, 3, '1,
                                      tbe_pkg::KIND_TYPED, '1, 7, '1));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_BOOL, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_BOOL, 1, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_TAGGED_NUM, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_TAGGED_NUM, 0, tbe_pkg::CLS_UNSIGNED, 3, '1,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_TAGGED_NUM, 0, tbe_pkg::CLS_FLOAT, 1,
                                      rand_wide(), tbe_pkg::KIND_MAP, 0,
                                      tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_TAGGED_NUM, 0, 2'd3, 2, '1,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_BARE_NUM, 0, tbe_pkg::CLS_SIGNED, 2, '1,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_BARE_NUM, 0, 2'd3, 3, '1,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_LEN_HDR, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_LEN_HDR, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_BINARY, 30, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_LEN_HDR, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_STRING, 31, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_LEN_HDR, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_ARRAY, '1, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_LEN_HDR, 0, tbe_pkg::CLS_FLOAT, 3, 0,
                                      tbe_pkg::KIND_TYPED, 5, tbe_pkg::ELEM_NUMBER, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_LEN_HDR, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_TYPED, 200, 3'd7, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_LEN_HDR, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      3'd5, 3, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_LEN_HDR, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      3'd7, '1, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_VARINT, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_VARINT, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 127, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_VARINT, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 128, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_VARINT, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, '1, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_ELEM_TAG, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_ELEM_TAG, 0, 2'd3, 1, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NUMBER, 0));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_RAW, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 8'hFF));
    pending_tokens.push_back(mk_token(tbe_pkg::CMD_RAW, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));
    pending_tokens.push_back(mk_token(4'd15, 1, 2'd3, 3, '1, 3'd7, '1, 3'd7, '1));
    pending_tokens.push_back(mk_token(4'd9, 0, tbe_pkg::CLS_SIGNED, 0, 0,
                                      tbe_pkg::KIND_MAP, 0, tbe_pkg::ELEM_NULL, 0));

    while (pending_tokens.size() < TOTAL_TOKENS) begin
      t = rand_token();
      pending_tokens.push_back(t);
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_tokens.size() != 0 || tok_ch.valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && expected_beats.size() == 0)
      $display("tagged_binary_object_encoder regression: pass");
    else
      $display("tagged_binary_object_encoder regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tbe_pkg.sv
rtl/tbe_if.sv
rtl/tbe_format.sv
rtl/tbe_emit.sv
rtl/tagged_binary_object_encoder.sv
dv/testbench.sv
